[hw/rtl/tun_pkg.sv]
// Package with the widths and types shared by the triangle unit normal pipeline.
package tun_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned EdgeW  = CoordW + 1;
  localparam int unsigned ProdW  = 2 * EdgeW;
  localparam int unsigned CrossW = ProdW + 1;
  localparam int unsigned MagW   = ProdW;
  localparam int unsigned HalfW  = MagW / 2;
  localparam int unsigned SqW    = 2 * MagW;
  localparam int unsigned RemW   = SqW + 66;
  localparam int unsigned AccW   = SqW + 34;
  localparam int unsigned OutW   = 32;
  localparam int unsigned NBits  = 31;
  localparam int unsigned PreStg = 7;
  localparam int unsigned NStg   = PreStg + NBits + 1;

  typedef logic signed [EdgeW-1:0] edge_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic [MagW-1:0]         mag_t;
  typedef logic [ProdW-1:0]        part_t;
  typedef logic [SqW-1:0]          sq_t;
  typedef logic signed [RemW-1:0]  rem_t;
  typedef logic signed [AccW-1:0]  acc_t;
  typedef logic [NBits-1:0]        unit_t;

endpackage

[hw/rtl/triangle_unit_normal.sv]
// Top level of the triangle unit normal: cross product and exact unit scaling.
//
// channel   dir  fields
// s_axis    in   tdata: ax, ay, az, bx, by_coord, bz, cx, cy, cz (32 bits each)
// m_axis    out  tdata: nx, ny, nz (32 bits each); tuser: degenerate
//
// The pipeline has 39 register stages and accepts one item every cycle while the output is not stalled.
// Seven stages form the edges, the cross product and the squared length, then
// 31 stages each decide one bit of the three magnitudes, and one stage applies the sign or zeroes a degenerate item.
// Reset clears only the valid bits. A stall on the output freezes the whole pipeline.
module triangle_unit_normal (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // ax, ay, az, bx, by_coord, bz, cx, cy, cz
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // nx, ny, nz
  output logic [95:0]  m_axis_tdata,
  // degenerate
  output logic         m_axis_tuser
);

  localparam int unsigned NB = tun_pkg::NBits;

  logic ce;
  logic [tun_pkg::NStg-1:0] vld_q;

  assign ce            = ~vld_q[tun_pkg::NStg-1] | m_axis_tready;
  assign s_axis_tready = ce;
  assign m_axis_tvalid = vld_q[tun_pkg::NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce) begin
      vld_q <= {vld_q[tun_pkg::NStg-2:0], s_axis_tvalid};
    end
  end

  tun_pkg::edge_t e_q [3];
  tun_pkg::edge_t f_q [3];
  tun_pkg::prod_t p_q [3];
  tun_pkg::prod_t m_q [3];
  tun_pkg::mag_t  mag_q [3];
  logic [2:0]     neg3_q, neg4_q, neg5_q, neg6_q;
  logic           deg3_q, deg4_q, deg5_q, deg6_q;
  tun_pkg::part_t hh_q [3];
  tun_pkg::part_t hl_q [3];
  tun_pkg::part_t ll_q [3];
  tun_pkg::sq_t   csq5_q [3];
  tun_pkg::sq_t   csq6_q [3];
  tun_pkg::sq_t   s6_q;

  tun_pkg::rem_t  r_q [NB+1][3];
  tun_pkg::acc_t  a_q [NB+1][3];
  tun_pkg::unit_t n_q [NB+1][3];
  tun_pkg::sq_t   s_q [NB+1];
  logic [2:0]     neg_q [NB+1];
  logic           deg_q [NB+1];

  logic [95:0]    out_data_q;
  logic           out_deg_q;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        e_q[i] <= $signed({s_axis_tdata[96+32*i+31], s_axis_tdata[96+32*i +: 32]})
                - $signed({s_axis_tdata[32*i+31], s_axis_tdata[32*i +: 32]});
        f_q[i] <= $signed({s_axis_tdata[192+32*i+31], s_axis_tdata[192+32*i +: 32]})
                - $signed({s_axis_tdata[32*i+31], s_axis_tdata[32*i +: 32]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      p_q[0] <= e_q[1] * f_q[2];
      m_q[0] <= e_q[2] * f_q[1];
      p_q[1] <= e_q[2] * f_q[0];
      m_q[1] <= e_q[0] * f_q[2];
      p_q[2] <= e_q[0] * f_q[1];
      m_q[2] <= e_q[1] * f_q[0];
    end
  end

  logic signed [tun_pkg::CrossW-1:0] cr_d [3];
  tun_pkg::mag_t                     mag_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr_d[i]  = $signed({p_q[i][tun_pkg::ProdW-1], p_q[i]})
               - $signed({m_q[i][tun_pkg::ProdW-1], m_q[i]});
      mag_d[i] = cr_d[i][tun_pkg::CrossW-1] ? tun_pkg::MagW'(-cr_d[i])
                                             : cr_d[i][tun_pkg::MagW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i]  <= mag_d[i];
        neg3_q[i] <= cr_d[i][tun_pkg::CrossW-1];
      end
      deg3_q <= (cr_d[0] == '0) && (cr_d[1] == '0) && (cr_d[2] == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        hh_q[i] <= mag_q[i][tun_pkg::MagW-1:tun_pkg::HalfW]
                 * mag_q[i][tun_pkg::MagW-1:tun_pkg::HalfW];
        hl_q[i] <= mag_q[i][tun_pkg::MagW-1:tun_pkg::HalfW]
                 * mag_q[i][tun_pkg::HalfW-1:0];
        ll_q[i] <= mag_q[i][tun_pkg::HalfW-1:0] * mag_q[i][tun_pkg::HalfW-1:0];
      end
      neg4_q <= neg3_q;
      deg4_q <= deg3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        csq5_q[i] <= {hh_q[i], {tun_pkg::MagW{1'b0}}}
                   + {{(tun_pkg::HalfW-1){1'b0}}, hl_q[i], {(tun_pkg::HalfW+1){1'b0}}}
                   + {{tun_pkg::MagW{1'b0}}, ll_q[i]};
      end
      neg5_q <= neg4_q;
      deg5_q <= deg4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      s6_q   <= csq5_q[0] + csq5_q[1] + csq5_q[2];
      csq6_q <= csq5_q;
      neg6_q <= neg5_q;
      deg6_q <= deg5_q;
    end
  end

  // The search starts from n = 0, so the odd factor 2n - 1 is -1.
  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        r_q[0][i] <= $signed({4'b0, csq6_q[i], 62'b0}) - $signed({66'b0, s6_q});
        a_q[0][i] <= -$signed({34'b0, s6_q});
        n_q[0][i] <= '0;
      end
      s_q[0]   <= s6_q;
      neg_q[0] <= neg6_q;
      deg_q[0] <= deg6_q;
    end
  end

  // Stage j decides bit K of n, keeping r = c^2 2^62 - (2n-1)^2 s and a = (2n-1) s.
  for (genvar j = 0; j < NB; j++) begin : g_bit
    localparam int unsigned K = NB - 1 - j;
    tun_pkg::rem_t step_d [3];
    tun_pkg::rem_t try_d  [3];
    logic [2:0]    take_d;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        step_d[i] = ($signed({{(tun_pkg::RemW-tun_pkg::AccW){a_q[j][i][tun_pkg::AccW-1]}},
                              a_q[j][i]}) <<< (K + 2))
                  + ($signed({{(tun_pkg::RemW-tun_pkg::SqW){1'b0}}, s_q[j]}) <<< (2*K + 2));
        try_d[i]  = r_q[j][i] - step_d[i];
        take_d[i] = ~n_q[j][i][NB-1] & ~try_d[i][tun_pkg::RemW-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce) begin
        for (int i = 0; i < 3; i++) begin
          if (take_d[i]) begin
            r_q[j+1][i] <= try_d[i];
            a_q[j+1][i] <= a_q[j][i]
                         + ($signed({{(tun_pkg::AccW-tun_pkg::SqW){1'b0}}, s_q[j]}) <<< (K + 1));
            n_q[j+1][i] <= n_q[j][i] | (tun_pkg::unit_t'(1) << K);
          end else begin
            r_q[j+1][i] <= r_q[j][i];
            a_q[j+1][i] <= a_q[j][i];
            n_q[j+1][i] <= n_q[j][i];
          end
        end
        s_q[j+1]   <= s_q[j];
        neg_q[j+1] <= neg_q[j];
        deg_q[j+1] <= deg_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        if (deg_q[NB]) begin
          out_data_q[32*i +: 32] <= '0;
        end else if (neg_q[NB][i]) begin
          out_data_q[32*i +: 32] <= -{1'b0, n_q[NB][i]};
        end else begin
          out_data_q[32*i +: 32] <= {1'b0, n_q[NB][i]};
        end
      end
      out_deg_q <= deg_q[NB];
    end
  end

  assign m_axis_tdata = out_data_q;
  assign m_axis_tuser = out_deg_q;

`ifndef NO_ASSERTIONS
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("Input ready does not follow the output stall.");

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("Degenerate item carries a nonzero normal.");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[31:30] == 2'b00 || m_axis_tdata[31:30] == 2'b11
                        || m_axis_tdata[31:0] == 32'h4000_0000)
                    && (m_axis_tdata[63:62] == 2'b00 || m_axis_tdata[63:62] == 2'b11
                        || m_axis_tdata[63:32] == 32'h4000_0000)
                    && (m_axis_tdata[95:94] == 2'b00 || m_axis_tdata[95:94] == 2'b11
                        || m_axis_tdata[95:64] == 32'h4000_0000)))
    else $error("Normal component outside the unit range.");
`endif

endmodule
